// ===== hw/rtl/lwpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpc_pkg: shared types and constants
// Parse states, word commands and widths for the line word palindrome counter.
// ----------------------------------------------------------------------------
package lwpc_pkg;

  localparam int MaxWordLen = 4096;
  localparam int AddrW      = $clog2(MaxWordLen);
  localparam int LenW       = $clog2(MaxWordLen + 1);
  localparam int CntW       = 16;
  localparam logic [CntW-1:0] CntMax = '1;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLa    = 8'h61;
  localparam logic [7:0] ChLz    = 8'h7a;
  localparam logic [7:0] ChUa    = 8'h41;
  localparam logic [7:0] ChUz    = 8'h5a;

  typedef enum logic [2:0] {
    PS_START = 3'd0,
    PS_WORD  = 3'd1,
    PS_SPACE = 3'd2,
    PS_CR    = 3'd3,
    PS_SKIP  = 3'd4
  } parse_state_t;

  typedef enum logic [1:0] {
    CMD_LETTER = 2'd0,
    CMD_WORD   = 2'd1,
    CMD_LINE   = 2'd2
  } cmd_t;

  // one command from the parser to the word engine
  typedef struct packed {
    cmd_t             cmd;
    logic [4:0]       code;
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  len;
    logic             err;
  } cmd_word_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_CMP  = 2'd2,
    BK_OUT  = 2'd3
  } back_state_t;

endpackage

// ===== hw/rtl/lwpc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpc_front: byte parser
// Classifies each byte, tracks the line state and issues word commands.
// ----------------------------------------------------------------------------
module lwpc_front import lwpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  logic [7:0] in_byte_value,
  output logic      cmd_valid,
  input  logic      cmd_ready,
  output cmd_word_t cmd_data
);

  parse_state_t    state_r, state_nxt;
  logic            err_r, err_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic            is_lc, is_uc, is_letter, take;
  logic [4:0]      code;

  assign in_full   = !cmd_ready;
  assign take      = in_push && cmd_ready;
  assign is_lc     = (in_byte_value >= ChLa) && (in_byte_value <= ChLz);
  assign is_uc     = (in_byte_value >= ChUa) && (in_byte_value <= ChUz);
  assign is_letter = is_lc || is_uc;
  assign code      = is_lc ? 5'(in_byte_value - ChLa) : 5'(in_byte_value - ChUa);

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    len_nxt   = len_r;
    cmd_valid = 1'b0;
    cmd_data  = '{cmd: CMD_LETTER, code: code, addr: len_r[AddrW-1:0],
                  len: len_r, err: err_r};
    if (take) begin
      unique case (state_r)
        PS_START, PS_WORD, PS_SPACE: begin
          if (is_letter) begin
            if (len_r < LenW'(MaxWordLen)) begin
              cmd_valid = 1'b1;
              len_nxt   = len_r + 1'b1;
              state_nxt = PS_WORD;
            end else begin
              err_nxt   = 1'b1;
              state_nxt = PS_SKIP;
            end
          end else if (in_byte_value == ChCr) begin
            if (state_r == PS_SPACE) err_nxt = 1'b1;
            state_nxt = PS_CR;
          end else if (in_byte_value == ChSpace && state_r == PS_WORD) begin
            cmd_valid    = 1'b1;
            cmd_data.cmd = CMD_WORD;
            len_nxt      = '0;
            state_nxt    = PS_SPACE;
          end else begin
            err_nxt   = 1'b1;
            state_nxt = PS_SKIP;
          end
        end
        PS_CR: begin
          if (in_byte_value == ChLf) begin
            cmd_valid    = 1'b1;
            cmd_data.cmd = CMD_LINE;
            state_nxt    = PS_START;
            err_nxt      = 1'b0;
            len_nxt      = '0;
          end else if (in_byte_value == ChCr) begin
            err_nxt = 1'b1;
          end else begin
            err_nxt   = 1'b1;
            state_nxt = PS_SKIP;
          end
        end
        default: begin
          if (in_byte_value == ChCr) state_nxt = PS_CR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_START;
      err_r   <= 1'b0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

// ===== hw/rtl/lwpc_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpc_fifo: command queue
// Two-entry queue that decouples the parser from the word engine.
// ----------------------------------------------------------------------------
module lwpc_fifo import lwpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  cmd_word_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output cmd_word_t rd_data
);

  cmd_word_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

endmodule

// ===== hw/rtl/lwpc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpc_back: word engine
// Stores letters, checks finished words from both ends, counts and reports.
// ----------------------------------------------------------------------------
module lwpc_back import lwpc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  cmd_word_t       cmd_data,
  output logic            out_empty,
  input  logic            out_pop,
  output logic            out_line_error,
  output logic [CntW-1:0] out_palindrome_count,
  output logic [CntW-1:0] out_word_count
);

  logic [4:0]       store_r [MaxWordLen];
  back_state_t      state_r, state_nxt;
  logic [AddrW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [LenW-1:0]  n_r, n_nxt;
  logic [4:0]       rd_lo_r, rd_hi_r;
  logic [CntW-1:0]  words_r, words_nxt, pals_r, pals_nxt;
  logic             line_r, line_nxt, err_r, err_nxt;
  logic             ovld_r, ovld_nxt;
  logic             oerr_r, oerr_nxt;
  logic [CntW-1:0]  opal_r, opal_nxt, owrd_r, owrd_nxt;
  logic             take, done_word, is_pal, fin;
  logic [CntW-1:0]  w_inc, p_inc;

  assign out_empty            = !ovld_r;
  assign out_line_error       = oerr_r;
  assign out_palindrome_count = opal_r;
  assign out_word_count       = owrd_r;
  // only a line end has to wait for a held result
  assign cmd_ready            = (state_r == BK_IDLE) && (!ovld_r || cmd_data.cmd != CMD_LINE);
  assign take                 = cmd_valid && cmd_ready;
  assign w_inc = (words_r == CntMax) ? words_r : words_r + 1'b1;

  always_ff @(posedge clk) begin
    if (take && cmd_data.cmd == CMD_LETTER) store_r[cmd_data.addr] <= cmd_data.code;
    rd_lo_r <= store_r[lo_r];
    rd_hi_r <= store_r[hi_r];
  end

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    n_nxt     = n_r;
    line_nxt  = line_r;
    err_nxt   = err_r;
    unique case (state_r)
      BK_IDLE: begin
        if (take && cmd_data.cmd != CMD_LETTER) begin
          lo_nxt   = '0;
          hi_nxt   = AddrW'(cmd_data.len - 1'b1);
          n_nxt    = cmd_data.len;
          line_nxt = cmd_data.cmd == CMD_LINE;
          err_nxt  = cmd_data.err;
          if (cmd_data.cmd == CMD_LINE && (cmd_data.err || cmd_data.len == '0))
            state_nxt = BK_OUT;
          else if (cmd_data.len < LenW'(2))
            state_nxt = BK_OUT;
          else
            state_nxt = BK_READ;
        end
      end
      BK_READ: state_nxt = BK_CMP;
      BK_CMP: begin
        if (rd_lo_r != rd_hi_r || LenW'({lo_r, 1'b0}) + LenW'(3) >= n_r)
          state_nxt = BK_OUT;
        else begin
          lo_nxt    = lo_r + 1'b1;
          hi_nxt    = hi_r - 1'b1;
          state_nxt = BK_READ;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    done_word = 1'b0;
    is_pal    = 1'b1;
    fin       = 1'b0;
    if (state_r == BK_CMP && state_nxt == BK_OUT) begin
      is_pal = rd_lo_r == rd_hi_r;
    end
    if (state_r == BK_OUT) begin
      fin       = line_r;
      done_word = !(line_r && (err_r || n_r == '0));
    end
  end

  // palindrome flag is carried in pal_hold_r from compare to finish
  logic pal_hold_r;
  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE) pal_hold_r <= 1'b1;
    else if (state_r == BK_CMP && state_nxt == BK_OUT) pal_hold_r <= is_pal;
  end

  always_comb begin
    p_inc     = (pals_r == CntMax || !pal_hold_r) ? pals_r : pals_r + 1'b1;
    words_nxt = done_word ? w_inc : words_r;
    pals_nxt  = done_word ? p_inc : pals_r;
    ovld_nxt  = ovld_r && !out_pop;
    oerr_nxt  = oerr_r;
    opal_nxt  = opal_r;
    owrd_nxt  = owrd_r;
    if (fin) begin
      ovld_nxt  = 1'b1;
      oerr_nxt  = err_r;
      opal_nxt  = err_r ? '0 : pals_nxt;
      owrd_nxt  = err_r ? '0 : words_nxt;
      words_nxt = '0;
      pals_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    n_r    <= n_nxt;
    line_r <= line_nxt;
    err_r  <= err_nxt;
    oerr_r <= oerr_nxt;
    opal_r <= opal_nxt;
    owrd_r <= owrd_nxt;
    if (!rst_n) begin
      state_r <= BK_IDLE;
      words_r <= '0;
      pals_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      words_r <= words_nxt;
      pals_r  <= pals_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

// ===== hw/rtl/line_word_palindrome_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_word_palindrome_counter: per-line word and palindrome counter
// Byte parser in front, command queue, word engine with letter store behind.
// ----------------------------------------------------------------------------
// A byte is taken whenever it is pushed while the queue has room. A
// space or CR LF ends a word; the word engine then compares letter pairs from
// both ends of its 4096-entry store, one pair per pass through its READ and
// CMP states, while bytes behind it fill the two-entry queue. One result per
// line, held until popped; only the next line end waits for that pop.
module line_word_palindrome_counter import lwpc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  logic [7:0]      in_byte_value,
  output logic            out_empty,
  input  logic            out_pop,
  output logic            out_line_error,
  output logic [CntW-1:0] out_palindrome_count,
  output logic [CntW-1:0] out_word_count
);

  logic      f_valid, f_ready, b_valid, b_ready;
  cmd_word_t f_data, b_data;

  lwpc_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_byte_value,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_data)
  );

  lwpc_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  lwpc_back u_back (
    .clk, .rst_n,
    .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd_data(b_data),
    .out_empty, .out_pop, .out_line_error, .out_palindrome_count, .out_word_count
  );

endmodule

// ===== hw/rtl/lwpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpc_props: port checks
// Watches the top-level ports of the counter.
// ----------------------------------------------------------------------------
module lwpc_props import lwpc_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_full,
  input logic            out_empty,
  input logic            out_pop,
  input logic            out_line_error,
  input logic [CntW-1:0] out_palindrome_count,
  input logic [CntW-1:0] out_word_count
);

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_line_error |-> out_palindrome_count == '0 && out_word_count == '0)
    else $error("error line with counts");

  a_pal_le: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_palindrome_count <= out_word_count)
    else $error("more palindromes than words");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_word_count))
    else $error("result dropped");

  a_rst: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("not idle after reset");

endmodule

bind line_word_palindrome_counter lwpc_props u_lwpc_props (.*);

// ===== tb/sv/lwpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpc_checker: line result predictor and scoreboard
// Watches accepted bytes, tracks the line parser and word counts itself,
// queues the expected line result on each CR LF and compares popped results.
// ----------------------------------------------------------------------------
module lwpc_checker import lwpc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  input  logic            in_full,
  input  logic [7:0]      in_byte_value,
  input  logic            out_empty,
  input  logic            out_pop,
  input  logic            out_line_error,
  input  logic [CntW-1:0] out_palindrome_count,
  input  logic [CntW-1:0] out_word_count,
  output int              fail_count,
  output int              pending_lines,
  output int              lines_checked,
  output int              error_lines
);

  typedef struct packed {
    logic            err;
    logic [CntW-1:0] pals;
    logic [CntW-1:0] words;
  } line_result_t;

  line_result_t expected_lines[$];

  parse_state_t    pst;
  logic            err_flag;
  logic [CntW-1:0] word_tally;
  logic [CntW-1:0] pal_tally;
  int              cur_len;
  logic [4:0]      letters[MaxWordLen];

  assign pending_lines = expected_lines.size();

  function automatic bit is_letter(input logic [7:0] b, output logic [4:0] code);
    if (b >= ChLa && b <= ChLz) begin
      code = 5'(b - ChLa);
      return 1;
    end
    if (b >= ChUa && b <= ChUz) begin
      code = 5'(b - ChUa);
      return 1;
    end
    code = '0;
    return 0;
  endfunction

  task automatic close_word();
    bit pal;
    pal = 1;
    for (int i = 0; 2 * i + 1 < cur_len; i++) begin
      if (letters[i] != letters[cur_len - 1 - i]) begin
        pal = 0;
        break;
      end
    end
    if (word_tally != CntMax) word_tally++;
    if (pal && pal_tally != CntMax) pal_tally++;
    cur_len = 0;
  endtask

  task automatic add_letter(input logic [4:0] code);
    if (cur_len < MaxWordLen) begin
      letters[cur_len] = code;
      cur_len++;
      pst = PS_WORD;
    end else begin
      err_flag = 1;
      pst = PS_SKIP;
    end
  endtask

  task automatic clear_line();
    pst = PS_START;
    err_flag = 0;
    word_tally = '0;
    pal_tally = '0;
    cur_len = 0;
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic [4:0] code;
    bit letter_hit;
    line_result_t r;
    letter_hit = is_letter(b, code);
    case (pst)
      PS_START: begin
        if (letter_hit) add_letter(code);
        else if (b == ChCr) pst = PS_CR;
        else begin err_flag = 1; pst = PS_SKIP; end
      end
      PS_WORD: begin
        if (letter_hit) add_letter(code);
        else if (b == ChSpace) begin close_word(); pst = PS_SPACE; end
        else if (b == ChCr) pst = PS_CR;
        else begin err_flag = 1; pst = PS_SKIP; end
      end
      PS_SPACE: begin
        if (letter_hit) add_letter(code);
        else if (b == ChCr) begin err_flag = 1; pst = PS_CR; end
        else begin err_flag = 1; pst = PS_SKIP; end
      end
      PS_CR: begin
        if (b == ChLf) begin
          if (!err_flag && cur_len > 0) close_word();
          r.err = err_flag;
          r.pals = err_flag ? '0 : pal_tally;
          r.words = err_flag ? '0 : word_tally;
          expected_lines.push_back(r);
          clear_line();
        end else if (b == ChCr) err_flag = 1;
        else begin err_flag = 1; pst = PS_SKIP; end
      end
      default: begin
        if (b == ChCr) pst = PS_CR;
      end
    endcase
  endtask

  always @(posedge clk) begin
    line_result_t e;
    if (!rst_n) begin
      clear_line();
      expected_lines.delete();
      fail_count <= 0;
      lines_checked <= 0;
      error_lines <= 0;
    end else begin
      if (in_push && !in_full) take_byte(in_byte_value);
      if (out_pop && !out_empty) begin
        if (expected_lines.size() == 0) begin
          $display("%0t: unexpected line result err=%0b pals=%0d words=%0d", $time,
                   out_line_error, out_palindrome_count, out_word_count);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_lines.pop_front();
          lines_checked <= lines_checked + 1;
          if (e.err) error_lines <= error_lines + 1;
          if (out_line_error !== e.err || out_palindrome_count !== e.pals ||
              out_word_count !== e.words) begin
            $display("%0t: mismatch expected err=%0b pals=%0d words=%0d,",
                     $time, e.err, e.pals, e.words);
            $display("%0t:          got err=%0b pals=%0d words=%0d",
                     $time, out_line_error, out_palindrome_count, out_word_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: line word palindrome counter testbench
// Sends directed and random byte lines through the push side under several
// idle and stall mixes; the checker predicts and compares each line result.
// ----------------------------------------------------------------------------
module tb_top;
  import lwpc_pkg::*;

  logic            clk = 0;
  logic            rst_n = 0;
  logic            in_push = 0;
  logic [7:0]      in_byte_value = '0;
  logic            out_pop = 0;
  logic            in_full, out_empty, out_line_error;
  logic [CntW-1:0] out_palindrome_count, out_word_count;
  int              fail_count, pending_lines, lines_checked, error_lines;
  int              send_idle_pct = 0;
  int              pop_stall_pct = 0;
  int              bytes_pushed = 0;
  longint          cycle_count = 0;
  logic [7:0]      line_bytes[$];

  localparam longint CycleLimit = 2_000_000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  line_word_palindrome_counter dut (.*);

  lwpc_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 0;
      @(posedge clk);
    end
    in_push <= 1;
    in_byte_value <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_pushed++;
  endtask

  task automatic send_line_bytes();
    while (line_bytes.size() > 0) send_byte(line_bytes.pop_front());
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'($urandom_range(25));
    return $urandom_range(1) ? ChLa + c : ChUa + c;
  endfunction

  // well-formed line with random words, palindromes mixed in
  task automatic build_good_line();
    int nw, len;
    logic [7:0] w[$];
    nw = $urandom_range(4);
    for (int k = 0; k < nw; k++) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
      w.delete();
      for (int i = 0; i < len; i++) w.push_back(rand_letter());
      if ($urandom_range(1))
        for (int i = 0; i < len / 2; i++)
          w[len - 1 - i] = w[i] ^ (w[i] & 8'h20) ^ (w[len - 1 - i] & 8'h20);
      if (k > 0) line_bytes.push_back(ChSpace);
      foreach (w[i]) line_bytes.push_back(w[i]);
    end
    line_bytes.push_back(ChCr);
    line_bytes.push_back(ChLf);
  endtask

  task automatic build_broken_line();
    int pos;
    build_good_line();
    pos = $urandom_range(line_bytes.size() - 1);
    case ($urandom_range(4))
      0: line_bytes.insert(pos, 8'($urandom));
      1: line_bytes.insert(pos, ChSpace);
      2: line_bytes.insert(pos, ChCr);
      3: line_bytes.insert(line_bytes.size() - 2, ChSpace);
      default: line_bytes.insert(pos, ChLf);
    endcase
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  task automatic wait_drained();
    while (pending_lines != 0) @(posedge clk);
    repeat (4200) @(posedge clk);
  endtask

  initial begin
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed lines
    push_str("abba Noon xyz Q\r\n");
    push_str("\r\n");
    push_str(" ab\r\n");
    push_str("ab  cd\r\n");
    push_str("ab \r\n");
    push_str("a\r\r\n");
    push_str("a\x00\xff\r\n");
    push_str("AZaz zA@[`{\r\n");
    push_str("\n\r\n");
    send_line_bytes();
    for (int i = 0; i < 256; i++) line_bytes.push_back(8'(i));
    line_bytes.push_back(ChCr);
    line_bytes.push_back(ChLf);
    send_line_bytes();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 22 : 52) : 0;
      pop_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 22 : 52) : 0;
      n = bytes_pushed;
      while (bytes_pushed - n < 210) begin
        if ($urandom_range(9) < 7) build_good_line();
        else if ($urandom_range(1)) build_broken_line();
        else repeat ($urandom_range(1, 5)) line_bytes.push_back(8'($urandom));
        send_line_bytes();
      end
    end
    push_str("\r\n");
    send_line_bytes();
    in_push <= 0;

    wait_drained();
    $display("lines checked: %0d (%0d in error), bytes pushed: %0d", lines_checked,
             error_lines, bytes_pushed);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lwpc_pkg.sv
hw/rtl/lwpc_front.sv
hw/rtl/lwpc_fifo.sv
hw/rtl/lwpc_back.sv
hw/rtl/line_word_palindrome_counter.sv
hw/rtl/lwpc_checker.sv
tb/sv/lwpc_checker.sv
tb/sv/tb_top.sv
